>>> rtl/assert_macros.svh
// assertion macros shared by the rule filter rtl
// no dependencies; synthesis builds see empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/icaf_pkg.sv
// shared types, codes and helpers for the ipv4 cidr access filter
// no dependencies
`default_nettype none

package icaf_pkg;

    // default table depth and command queue depth (power of two)
    localparam int MAX_RULES_DEFAULT = 16;
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MATCH      = 3'd1,
        ST_NOT_LOCAL  = 3'd2,
        ST_BAD_PREFIX = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_CLEAR = 3'd1,
        OP_ADD   = 3'd2,
        OP_BAD   = 3'd3,
        OP_CHECK = 3'd4
    } op_t;

    // one queued beat: addr is the peer for check, the network for add
    typedef struct packed {
        op_t         op;
        logic [31:0] addr;
        logic [31:0] mask;
    } icaf_entry_t;

    localparam logic [31:0] LOOP_MASK = 32'hFF00_0000;
    localparam logic [31:0] LOOP_NET  = 32'h7F00_0000;
    localparam logic [31:0] P10_MASK  = 32'hFF00_0000;
    localparam logic [31:0] P10_NET   = 32'h0A00_0000;
    localparam logic [31:0] P172_MASK = 32'hFFF0_0000;
    localparam logic [31:0] P172_NET  = 32'hAC10_0000;
    localparam logic [31:0] P192_MASK = 32'hFFFF_0000;
    localparam logic [31:0] P192_NET  = 32'hC0A8_0000;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    // loopback or private range
    function automatic logic is_local(input logic [31:0] a);
        is_local = ((a & LOOP_MASK) == LOOP_NET)
                || ((a & P10_MASK) == P10_NET)
                || ((a & P172_MASK) == P172_NET)
                || ((a & P192_MASK) == P192_NET);
    endfunction

    // prefix mask for lengths 0..32; shift by 32 empties the word
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        prefix_mask = ~(ALL_ONES >> len);
    endfunction

endpackage

`default_nettype wire

>>> rtl/icaf_front.sv
// front end: takes command beats, checks prefix, forms mask and network
// depends on icaf_pkg
`default_nettype none

module icaf_front
    import icaf_pkg::*;
(
    input  wire logic        start,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] address,
    input  wire logic [5:0]  prefix_length,
    input  wire logic        q_full,
    output logic             busy,
    output logic             push,
    output icaf_entry_t      entry
);

    logic [31:0] mask;

    // accept whenever the queue has room
    assign busy = q_full;
    assign push = start && !q_full;
    assign mask = prefix_mask(prefix_length);

    // classify the command
    always_comb
    begin
        entry.addr = address;
        entry.mask = mask;
        unique case (cmd_t'(cmd))
            CMD_CLEAR:
            begin
                entry.op = OP_CLEAR;
            end
            CMD_ADD:
            begin
                entry.addr = address & mask;
                if (prefix_length > 6'd32)
                begin
                    entry.op = OP_BAD;
                end
                else
                begin
                    entry.op = OP_ADD;
                end
            end
            CMD_CHECK:
            begin
                entry.op = OP_CHECK;
            end
            CMD_UNUSED:
            begin
                entry.op = OP_NOP;
            end
            default:
            begin
                entry.op = OP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/icaf_queue.sv
// short command queue between front and back
// depends on icaf_pkg
`default_nettype none

module icaf_queue
    import icaf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire icaf_entry_t entry_in,
    input  wire logic        pop,
    output icaf_entry_t      entry_out,
    output logic             valid,
    output logic             full
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    icaf_entry_t   slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign valid     = (cnt_reg != '0);
    assign full      = (cnt_reg == CW'(QUEUE_DEPTH));
    assign entry_out = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/icaf_back.sv
// back end: rule table, clear/add execution and serial rule scan for check
// depends on icaf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module icaf_back
    import icaf_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        local_only,
    input  wire icaf_entry_t entry,
    input  wire logic        q_valid,
    output logic             pop,
    output logic             done,
    output logic             allowed,
    output logic [2:0]       status
);

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [31:0]   peer_reg, peer_next;
    logic          done_reg, done_next;
    logic          allowed_reg, allowed_next;
    status_t       status_reg, status_next;

    // rule memory: network in the top half, mask in the bottom half
    logic [63:0]   rule_mem [MAX_RULES];
    logic [63:0]   rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic          issue;
    logic          hit;

    assign wr_addr = count_reg[AW-1:0];
    assign rd_addr = idx_reg[AW-1:0];
    assign issue   = (idx_reg != count_reg);
    assign hit     = pend_reg && ((peer_reg & rd_data_reg[31:0]) == rd_data_reg[63:32]);

    assign done    = done_reg;
    assign allowed = allowed_reg;
    assign status  = status_reg;

    // command execution and scan sequencing
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pend_next    = 1'b0;
        peer_next    = peer_reg;
        done_next    = 1'b0;
        allowed_next = 1'b0;
        status_next  = ST_OK;
        wr_en        = 1'b0;
        pop          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    unique case (entry.op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        OP_ADD:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CW'(MAX_RULES))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_BAD:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_BAD_PREFIX;
                        end
                        OP_CHECK:
                        begin
                            peer_next  = entry.addr;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                        OP_NOP:
                        begin
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                priority if (hit)
                begin
                    done_next   = 1'b1;
                    status_next = ST_MATCH;
                    state_next  = S_IDLE;
                end
                else if (!issue && !pend_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (local_only && !is_local(peer_reg))
                    begin
                        status_next = ST_NOT_LOCAL;
                    end
                    else
                    begin
                        allowed_next = 1'b1;
                    end
                end
                else
                begin
                    pend_next = issue;
                    if (issue)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
            allowed_reg <= 1'b0;
            status_reg  <= ST_OK;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
            allowed_reg <= allowed_next;
            status_reg  <= status_next;
        end
    end

    // peer address held for the scan
    always_ff @(posedge clk)
    begin
        peer_reg <= peer_next;
    end

    // rule memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rule_mem[wr_addr] <= {entry.addr, entry.mask};
        end
        rd_data_reg <= rule_mem[rd_addr];
    end

    `ASSERT_IMPLIES(a_allowed_ok, clk, rst_n, done_reg && allowed_reg, status_reg == ST_OK)
    `ASSERT_IMPLIES(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(MAX_RULES))
    `ASSERT_NEXT(a_hit_reports, clk, rst_n, (state_reg == S_SCAN) && hit, done_reg && (status_reg == ST_MATCH) && (state_reg == S_IDLE))

endmodule

`default_nettype wire

>>> rtl/ipv4_cidr_access_filter.sv
// ipv4 cidr deny-list filter: top level with config register
// depends on icaf_pkg, icaf_front, icaf_queue, icaf_back
//
// usage:
//   command beats enter on start/cmd/address/prefix_length and are taken
//   at a clock edge with start high and busy low. cmd clears the rule
//   table, adds a rule (prefix over 32 rejected, full table flagged) or
//   checks a peer address against the stored rules.
//   every beat gives one result on allowed/status, shown for one cycle
//   with done high; the receiver cannot stall, results are never held.
//   cfg_we/cfg_wdata write local_only, which limits checks to loopback
//   and private ranges; write it only while no command is in flight.
//   a clear or add beat passes through the queue and its result is
//   registered in the back end when the back end is free; a check scans
//   the stored rules in order and ends early on a match.
//   the back end runs one clear/add per cycle while no scan is running;
//   a check holds it until its scan ends, since the rule memory has a
//   single read port and is scanned one rule per cycle. a two-entry
//   queue lets the front take beats while a scan is running; busy rises
//   when full.
//   reset empties the table and queue and clears local_only.
`default_nettype none

module ipv4_cidr_access_filter
    import icaf_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] address,
    input  wire logic [5:0]  prefix_length,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    output logic             done,
    output logic             allowed,
    output logic [2:0]       status
);

    logic        local_only_reg, local_only_next;
    logic        q_full;
    logic        q_valid;
    logic        push;
    logic        pop;
    icaf_entry_t front_entry;
    icaf_entry_t head_entry;

    // local_only config register
    assign local_only_next = cfg_we ? cfg_wdata : local_only_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_only_reg <= 1'b0;
        end
        else
        begin
            local_only_reg <= local_only_next;
        end
    end

    icaf_front u_front (
        .start         (start),
        .cmd           (cmd),
        .address       (address),
        .prefix_length (prefix_length),
        .q_full        (q_full),
        .busy          (busy),
        .push          (push),
        .entry         (front_entry)
    );

    icaf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (front_entry),
        .pop       (pop),
        .entry_out (head_entry),
        .valid     (q_valid),
        .full      (q_full)
    );

    icaf_back #(
        .MAX_RULES (MAX_RULES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .local_only (local_only_reg),
        .entry      (head_entry),
        .q_valid    (q_valid),
        .pop        (pop),
        .done       (done),
        .allowed    (allowed),
        .status     (status)
    );

endmodule

`default_nettype wire
